FILE: hw/rtl/base58_address_decoder_defines.svh
// ----------------------------------------------------------------------------
// base58 address decoder assertion macros
// shared property wrappers, clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef BASE58_ADDRESS_DECODER_DEFINES_SVH
`define BASE58_ADDRESS_DECODER_DEFINES_SVH

// same-cycle implication
`define B58_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define B58_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/b58_pkg.sv
// ----------------------------------------------------------------------------
// b58_pkg
// types, constants and the symbol lookup for the base58 address decoder
// ----------------------------------------------------------------------------
`default_nettype none

package b58_pkg;

  localparam int B58_DECODED_BYTES = 25;
  localparam int B58_RADIX         = 58;
  localparam logic [5:0] B58_MIN_LEN = 6'd26;
  localparam logic [5:0] B58_MAX_LEN = 6'd35;
  localparam logic [5:0] B58_CNT_MAX = 6'd63;
  localparam logic [7:0] B58_VER_P2PKH = 8'h31; // '1'
  localparam logic [7:0] B58_VER_P2SH  = 8'h33; // '3'

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_LEN  = 3'd1,
    ST_BAD_VER  = 3'd2,
    ST_BAD_CHAR = 3'd3,
    ST_OVERFLOW = 3'd4
  } b58_status_t;

  // one step travelling down the cell row
  typedef struct packed {
    logic        en;     // step updates the accumulator
    logic        first;  // first character of an address
    logic        last;   // last character of an address
    logic        cap;    // last step whose length and version passed
    logic        bad;    // invalid character seen in this address
    b58_status_t pre;    // length / version verdict known at entry
    logic [5:0]  carry;  // digit at entry, carry between cells after
  } b58_tok_t;

  localparam b58_tok_t TOK_NULL = '{en: 1'b0, first: 1'b0, last: 1'b0, cap: 1'b0,
                                    bad: 1'b0, pre: ST_OK, carry: 6'd0};

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b58_digit_t;

  function automatic b58_digit_t b58_digit(input logic [7:0] c);
    b58_digit_t d;
    d.ok  = 1'b1;
    d.val = 6'd0;
    case (c) inside
      [8'h31:8'h39]: d.val = 6'(c - 8'h31);
      [8'h41:8'h48]: d.val = 6'(c - 8'h41 + 8'd9);
      [8'h4a:8'h4e]: d.val = 6'(c - 8'h4a + 8'd17);
      [8'h50:8'h5a]: d.val = 6'(c - 8'h50 + 8'd22);
      [8'h61:8'h6b]: d.val = 6'(c - 8'h61 + 8'd33);
      [8'h6d:8'h7a]: d.val = 6'(c - 8'h6d + 8'd44);
      default:       d.ok  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/b58_cell.sv
// ----------------------------------------------------------------------------
// b58_cell
// one accumulator byte: times 58 plus incoming carry, carry on to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module b58_cell
  import b58_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     adv,
  input  wire b58_tok_t tok_in,
  output b58_tok_t      tok_out,
  output logic [7:0]    shadow
);

  logic [7:0]  acc;
  logic [7:0]  acc_old;
  logic [7:0]  acc_next;
  logic [13:0] prod;
  b58_tok_t    tok_next;

  always_comb begin
    acc_old  = tok_in.first ? 8'd0 : acc;
    prod     = 14'(acc_old) * 14'(B58_RADIX) + 14'(tok_in.carry);
    acc_next = tok_in.en ? prod[7:0] : acc_old;
    tok_next = tok_in;
    tok_next.carry = tok_in.en ? prod[13:8] : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= TOK_NULL;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

  // payload, no reset: each address starts with a first step
  always_ff @(posedge clk) begin
    if (adv) begin
      acc <= acc_next;
      if (tok_in.last && tok_in.cap) begin
        shadow <= acc_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/b58_obuf.sv
// ----------------------------------------------------------------------------
// b58_obuf
// result buffer: holds the decoded bytes or one status item and drains them
// ----------------------------------------------------------------------------
`default_nettype none

module b58_obuf
  import b58_pkg::*;
#(
  parameter int DECODED_BYTES = B58_DECODED_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire b58_status_t                   ld_status,
  input  wire logic [DECODED_BYTES-1:0][7:0] ld_bytes,
  input  wire logic                          ready,
  output logic                               valid,
  output logic                               can_load,
  output logic [7:0]                         byte_value,
  output logic [4:0]                         byte_index,
  output b58_status_t                        status,
  output logic                               last_result
);

  localparam int CW = $clog2(DECODED_BYTES + 1);

  logic [DECODED_BYTES-1:0][7:0] obuf;
  logic [CW-1:0]                 ocnt;
  logic [4:0]                    oidx;
  logic                          xfer;

  assign valid       = (ocnt != '0);
  assign xfer        = valid && ready;
  assign can_load    = (ocnt == '0) || ((ocnt == CW'(1)) && ready);
  assign byte_value  = obuf[0];
  assign byte_index  = oidx;
  assign last_result = (ocnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
    end else if (load) begin
      ocnt <= (ld_status == ST_OK) ? CW'(DECODED_BYTES) : CW'(1);
    end else if (xfer) begin
      ocnt <= ocnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      oidx   <= 5'd0;
      status <= ld_status;
      if (ld_status == ST_OK) begin
        obuf <= ld_bytes;
      end else begin
        obuf[0] <= 8'd0;
      end
    end else if (xfer) begin
      oidx <= oidx + 5'd1;
      for (int i = 0; i < DECODED_BYTES - 1; i++) begin
        obuf[i] <= obuf[i+1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/base58_address_decoder.sv
// ----------------------------------------------------------------------------
// base58_address_decoder
// streaming base58 address decoder built as a row of byte cells
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one address character per transfer, s_tlast on the last one.
//   m_* returns either DECODED_BYTES decoded bytes, most significant first,
//   with status ok, or a single status transfer (bad length, bad version
//   character, invalid character, overflow) with byte_value 0. m_tlast marks
//   the final transfer of each address.
// throughput: one character per cycle while s_tready is high. each character
//   enters the lsb cell and its carry ripples one cell per cycle toward the msb
//   cell, so up to DECODED_BYTES characters are in flight at once.
// path: the last character taken goes through the entry register, then the
//   step register of each cell from lsb to msb, then the result buffer load.
// stall: when m_tready is low and a finished address reaches the end of the
//   row while the result buffer is still busy, the whole row holds and
//   s_tready drops. a second length/version-clean address may not end while
//   an earlier one is still in the row, which only matters when
//   DECODED_BYTES exceeds 25.
// reset: rst clears the counters, the in-flight steps and the result buffer;
//   accumulator bytes are cleared by the first character of each address.
// ----------------------------------------------------------------------------
`default_nettype none

`include "base58_address_decoder_defines.svh"

module base58_address_decoder
  import b58_pkg::*;
#(
  parameter int DECODED_BYTES = B58_DECODED_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // last_char
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] byte_value, [12:8] byte_index, [15:13] status
  output logic             m_tlast    // last_result
);

  // entry side counters for the address being received
  logic [5:0] char_count;
  logic       version_ok;
  logic       bad_seen;
  logic       cap_busy;

  logic       adv;
  logic       accept;
  logic       first;
  logic [5:0] cnt_new;
  logic       ver_new;
  logic       bad_prev;
  b58_digit_t dig;
  b58_status_t pre;
  logic       in_cap;
  b58_tok_t   tok_new;

  // toks[DECODED_BYTES] is the entry register, toks[0] leaves the msb cell
  b58_tok_t                      toks [DECODED_BYTES+1];
  logic [DECODED_BYTES-1:0][7:0] shadows;

  // end of row
  logic        ovf_sticky;
  logic        ovf_eff;
  logic        exit_last;
  b58_status_t fin_status;
  logic        load;

  logic        ob_can_load;
  logic [7:0]  byte_value;
  logic [4:0]  byte_index;
  b58_status_t status;

  // character classification and length / version verdict
  always_comb begin
    first    = (char_count == 6'd0);
    dig      = b58_digit(s_tdata);
    cnt_new  = first ? 6'd1 : ((char_count == B58_CNT_MAX) ? char_count : char_count + 6'd1);
    ver_new  = first ? ((s_tdata == B58_VER_P2PKH) || (s_tdata == B58_VER_P2SH)) : version_ok;
    bad_prev = first ? 1'b0 : bad_seen;
    if ((cnt_new < B58_MIN_LEN) || (cnt_new > B58_MAX_LEN)) begin
      pre = ST_BAD_LEN;
    end else if (!ver_new) begin
      pre = ST_BAD_VER;
    end else begin
      pre = ST_OK;
    end
    in_cap = s_tlast && (pre == ST_OK);

    tok_new.en    = dig.ok && !bad_prev;
    tok_new.first = first;
    tok_new.last  = s_tlast;
    tok_new.cap   = in_cap;
    tok_new.bad   = bad_prev || !dig.ok;
    tok_new.pre   = pre;
    tok_new.carry = dig.val;
  end

  // the row moves unless a finished address cannot enter the result buffer;
  // the shadows free up on the edge where the parked address loads
  assign exit_last = toks[0].last;
  assign adv       = !exit_last || ob_can_load;
  assign s_tready  = adv && !(cap_busy && in_cap && !(load && toks[0].cap));
  assign accept    = s_tvalid && s_tready;
  assign load      = adv && exit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= 6'd0;
      version_ok <= 1'b0;
      bad_seen   <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        char_count <= 6'd0;
        version_ok <= 1'b0;
        bad_seen   <= 1'b0;
      end else begin
        char_count <= cnt_new;
        version_ok <= ver_new;
        bad_seen   <= tok_new.bad;
      end
    end
  end

  // entry register: a null step fills the row when nothing is offered
  always_ff @(posedge clk) begin
    if (rst) begin
      toks[DECODED_BYTES] <= TOK_NULL;
    end else if (adv) begin
      toks[DECODED_BYTES] <= accept ? tok_new : TOK_NULL;
    end
  end

  // only one clean address may have its bytes parked in the shadows
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_busy <= 1'b0;
    end else if (accept && in_cap) begin
      cap_busy <= 1'b1;
    end else if (load && toks[0].cap) begin
      cap_busy <= 1'b0;
    end
  end

  // cell DECODED_BYTES-1 holds the least significant byte
  for (genvar k = 0; k < DECODED_BYTES; k++) begin : g_row
    b58_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (toks[k+1]),
      .tok_out (toks[k]),
      .shadow  (shadows[k])
    );
  end

  // carry out of the msb cell on a live step is an overflow; it outranks a
  // later invalid character since steps after an invalid one carry nothing
  always_comb begin
    ovf_eff = (toks[0].first ? 1'b0 : ovf_sticky) ||
              (toks[0].en && (toks[0].carry != 6'd0));
    if (toks[0].pre != ST_OK) begin
      fin_status = toks[0].pre;
    end else if (ovf_eff) begin
      fin_status = ST_OVERFLOW;
    end else if (toks[0].bad) begin
      fin_status = ST_BAD_CHAR;
    end else begin
      fin_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_sticky <= 1'b0;
    end else if (adv) begin
      ovf_sticky <= toks[0].last ? 1'b0 : ovf_eff;
    end
  end

  b58_obuf #(
    .DECODED_BYTES (DECODED_BYTES)
  ) u_obuf (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .ld_status   (fin_status),
    .ld_bytes    (shadows),
    .ready       (m_tready),
    .valid       (m_tvalid),
    .can_load    (ob_can_load),
    .byte_value  (byte_value),
    .byte_index  (byte_index),
    .status      (status),
    .last_result (m_tlast)
  );

  assign m_tdata = {status, byte_index, byte_value};

  // error transfers carry a zero byte and close the address
  `B58_ASSERT_NOW(a_err_item, m_tvalid && (status != ST_OK), (byte_value == 8'd0) && m_tlast, "error transfer malformed")
  // a finished address always shows up at the output next cycle
  `B58_ASSERT_NEXT(a_load_valid, load, m_tvalid, "loaded result not presented")
  // idle steps never carry anything out of the row
  `B58_ASSERT_NOW(a_null_carry, !toks[0].en, toks[0].carry == 6'd0, "carry on disabled step")

endmodule

`default_nettype wire
